FILE: sv/pfc_buffer_admission_ecn_defines.svh
// Assertion macros for the buffer admission and ECN marking block.
// Included by the top-level RTL file, which carries concurrent assertions; no other dependencies.
`ifndef PFC_BUFFER_ADMISSION_ECN_DEFINES_SVH
`define PFC_BUFFER_ADMISSION_ECN_DEFINES_SVH

`ifndef SYNTHESIS

`define PFCBA_ASSERT_RST(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

`define PFCBA_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define PFCBA_ASSERT_RST(label, clk, rstn, prop, msg)

`define PFCBA_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

FILE: sv/pfcba_pkg.sv
// Shared types, constants and a helper function of the buffer admission block.
// No dependencies; every other RTL file imports this package.
package pfcba_pkg;

    localparam int NUM_PORTS    = 64;
    localparam int NUM_QUEUES   = 8;
    localparam int BYTE_WIDTH   = 24;

    localparam int QSTORE_DEPTH = NUM_PORTS * NUM_QUEUES;
    localparam int QIDX_W       = $clog2(QSTORE_DEPTH);

    localparam int CMD_W   = 3;
    localparam int PORT_W  = 6;
    localparam int QUEUE_W = 3;
    localparam int SIZE_W  = 14;
    localparam int RAND_W  = 16;
    localparam int PKT_W   = 16;
    localparam int LEVEL_W = 24;

    localparam int RES_W  = 20;
    localparam int HDRM_W = 24;
    localparam int KTH_W  = 24;
    localparam int PROB_W = 16;

    localparam int WIDE_W     = (BYTE_WIDTH > KTH_W) ? BYTE_WIDTH : KTH_W;
    localparam int CALC_W     = WIDE_W + 2;
    localparam int ECN_PROD_W = PROB_W + WIDE_W;

    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 5;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;

    localparam logic [CMD_W-1:0] CMD_ING_ENQ   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ING_REL   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_EGR_ENQ   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_EGR_REL   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SET_PAUSE = 3'd4;
    localparam logic [CMD_W-1:0] CMD_CLR_PAUSE = 3'd5;

    localparam logic [REG_IDX_W-1:0] REG_RESERVE  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_RESUME   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_HEADROOM = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_KMIN     = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_KMAX     = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_PMAX     = 3'd5;

    localparam logic [RES_W-1:0]  RESERVE_RST  = 20'd4096;
    localparam logic [RES_W-1:0]  RESUME_RST   = 20'd3072;
    localparam logic [HDRM_W-1:0] HEADROOM_RST = 24'd0;
    localparam logic [KTH_W-1:0]  KMIN_RST     = 24'd100000;
    localparam logic [KTH_W-1:0]  KMAX_RST     = 24'd400000;
    localparam logic [PROB_W-1:0] PMAX_RST     = 16'd13107;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [PORT_W-1:0]  port;
        logic [QUEUE_W-1:0] queue;
        logic [SIZE_W-1:0]  packet_size;
        logic [RAND_W-1:0]  random_value;
    } pfcba_in_t;

    typedef struct packed {
        logic               admitted;
        logic               pause_needed;
        logic               resume_needed;
        logic               ecn_mark;
        logic [LEVEL_W-1:0] ingress_level;
        logic [LEVEL_W-1:0] egress_level;
        logic [LEVEL_W-1:0] shared_level;
        logic               count_error;
    } pfcba_out_t;

    typedef struct packed {
        logic [RES_W-1:0]  reserve_bytes;
        logic [RES_W-1:0]  resume_margin;
        logic [HDRM_W-1:0] headroom_bytes;
        logic [KTH_W-1:0]  ecn_kmin;
        logic [KTH_W-1:0]  ecn_kmax;
        logic [PROB_W-1:0] ecn_pmax;
    } pfcba_cfg_t;

    typedef struct packed {
        logic [BYTE_WIDTH-1:0] ingress_count;
        logic [BYTE_WIDTH-1:0] headroom_count;
        logic [BYTE_WIDTH-1:0] egress_count;
        logic                  paused_flag;
        logic [PKT_W-1:0]      ingress_packets;
        logic [PKT_W-1:0]      egress_packets;
    } pfcba_qentry_t;

    typedef struct packed {
        pfcba_out_t            res;
        logic                  ecn_en;
        logic                  above_kmax;
        logic                  above_kmin;
        logic [BYTE_WIDTH-1:0] lvl_diff;
        logic [KTH_W-1:0]      ecn_span;
        logic [RAND_W-1:0]     rnd;
    } pfcba_mid_t;

    function automatic logic [QIDX_W-1:0] qidx(input logic [PORT_W-1:0] port,
                                               input logic [QUEUE_W-1:0] queue);
        return QIDX_W'(QIDX_W'(port) * QIDX_W'(NUM_QUEUES) + QIDX_W'(queue));
    endfunction

endpackage

FILE: sv/pfcba_regs.sv
// APB register file holding the admission, pause and ECN settings.
// Depends on pfcba_pkg for the register layout and reset values.
module pfcba_regs (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [pfcba_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [pfcba_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [pfcba_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                pready,
    output pfcba_pkg::pfcba_cfg_t               cfg
);
    import pfcba_pkg::*;

    pfcba_cfg_t            cfg_reg;
    pfcba_cfg_t            cfg_next;
    logic [REG_IDX_W-1:0]  reg_idx;
    logic                  wr_en;

    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (reg_idx)
                REG_RESERVE:  cfg_next.reserve_bytes  = pwdata[RES_W-1:0];
                REG_RESUME:   cfg_next.resume_margin  = pwdata[RES_W-1:0];
                REG_HEADROOM: cfg_next.headroom_bytes = pwdata[HDRM_W-1:0];
                REG_KMIN:     cfg_next.ecn_kmin       = pwdata[KTH_W-1:0];
                REG_KMAX:     cfg_next.ecn_kmax       = pwdata[KTH_W-1:0];
                REG_PMAX:     cfg_next.ecn_pmax       = pwdata[PROB_W-1:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.reserve_bytes  <= RESERVE_RST;
            cfg_reg.resume_margin  <= RESUME_RST;
            cfg_reg.headroom_bytes <= HEADROOM_RST;
            cfg_reg.ecn_kmin       <= KMIN_RST;
            cfg_reg.ecn_kmax       <= KMAX_RST;
            cfg_reg.ecn_pmax       <= PMAX_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        case (reg_idx)
            REG_RESERVE:  prdata = APB_DATA_W'(cfg_reg.reserve_bytes);
            REG_RESUME:   prdata = APB_DATA_W'(cfg_reg.resume_margin);
            REG_HEADROOM: prdata = APB_DATA_W'(cfg_reg.headroom_bytes);
            REG_KMIN:     prdata = APB_DATA_W'(cfg_reg.ecn_kmin);
            REG_KMAX:     prdata = APB_DATA_W'(cfg_reg.ecn_kmax);
            REG_PMAX:     prdata = APB_DATA_W'(cfg_reg.ecn_pmax);
            default:      prdata = '0;
        endcase
    end

endmodule

FILE: sv/pfcba_qstore.sv
// Per-queue counter memory with a clearing pass after reset and a registered read port.
// Depends on pfcba_pkg for the entry type and the memory depth.
module pfcba_qstore (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            rd_en,
    input  logic [pfcba_pkg::QIDX_W-1:0]    rd_addr,
    output pfcba_pkg::pfcba_qentry_t        rd_data,
    input  logic                            wr_en,
    input  logic [pfcba_pkg::QIDX_W-1:0]    wr_addr,
    input  pfcba_pkg::pfcba_qentry_t        wr_data,
    output logic                            clr_busy
);
    import pfcba_pkg::*;

    pfcba_qentry_t       mem [QSTORE_DEPTH];
    pfcba_qentry_t       rd_data_reg;
    logic [QIDX_W-1:0]   clr_addr_reg;
    logic [QIDX_W-1:0]   clr_addr_next;
    logic                clr_busy_reg;
    logic                clr_busy_next;

    assign rd_data  = rd_data_reg;
    assign clr_busy = clr_busy_reg;

    always_comb begin
        clr_addr_next = clr_addr_reg;
        clr_busy_next = clr_busy_reg;
        if (clr_busy_reg) begin
            if (clr_addr_reg == QIDX_W'(QSTORE_DEPTH - 1)) begin
                clr_busy_next = 1'b0;
            end else begin
                clr_addr_next = clr_addr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
            clr_busy_reg <= 1'b1;
        end else begin
            clr_addr_reg <= clr_addr_next;
            clr_busy_reg <= clr_busy_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (clr_busy_reg) begin
            mem[clr_addr_reg] <= '0;
        end else if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

endmodule

FILE: sv/pfcba_update.sv
// Counter update for one packet event: admission, split, release, saturation and PFC advice.
// Depends on pfcba_pkg for the item, entry, settings and intermediate result types.
module pfcba_update (
    input  pfcba_pkg::pfcba_in_t                item,
    input  pfcba_pkg::pfcba_qentry_t            cur,
    input  logic [pfcba_pkg::BYTE_WIDTH-1:0]    shared_cur,
    input  pfcba_pkg::pfcba_cfg_t               cfg,
    output logic                                in_range,
    output pfcba_pkg::pfcba_qentry_t            nxt,
    output logic [pfcba_pkg::BYTE_WIDTH-1:0]    shared_nxt,
    output pfcba_pkg::pfcba_mid_t               mid
);
    import pfcba_pkg::*;

    localparam logic [CALC_W-1:0] BYTE_MAX = CALC_W'((64'd1 << BYTE_WIDTH) - 64'd1);

    logic [CALC_W-1:0] ic, hc, ec, st, sz, rsv, thr, hb, kmin, kmax;
    logic [CALC_W-1:0] su, nb, over, fh, rest, fs, sh_add, sum_hc, sum_st, sum_ec;
    logic [CALC_W-1:0] ic_n, hc_n, ec_n, st_n, nsu;
    logic [PKT_W-1:0]  ip_n, ep_n;
    logic              p_n, admit, err;

    always_comb begin
        ic     = CALC_W'(cur.ingress_count);
        hc     = CALC_W'(cur.headroom_count);
        ec     = CALC_W'(cur.egress_count);
        st     = CALC_W'(shared_cur);
        sz     = CALC_W'(item.packet_size);
        rsv    = CALC_W'(cfg.reserve_bytes);
        thr    = CALC_W'(cfg.reserve_bytes) << 2;
        hb     = CALC_W'(cfg.headroom_bytes);
        kmin   = CALC_W'(cfg.ecn_kmin);
        kmax   = CALC_W'(cfg.ecn_kmax);
        su     = (ic > rsv) ? ic - rsv : '0;
        nb     = ic + sz;
        over   = nb - rsv;
        fh     = (hc < sz) ? hc : sz;
        rest   = sz - fh;
        fs     = (rest < su) ? rest : su;
        sh_add = (sz < over) ? sz : over;
        sum_hc = hc + sz;
        sum_st = st + sh_add;
        sum_ec = ec + sz;

        ic_n  = ic;
        hc_n  = hc;
        ec_n  = ec;
        st_n  = st;
        p_n   = cur.paused_flag;
        ip_n  = cur.ingress_packets;
        ep_n  = cur.egress_packets;
        admit = 1'b0;
        err   = 1'b0;

        case (item.cmd)
            CMD_ING_ENQ: begin
                if (!((sz + hc > hb) && (sz + su > thr))) begin
                    admit = 1'b1;
                    if (nb <= rsv || over <= thr) begin
                        if (nb > BYTE_MAX) begin
                            ic_n = BYTE_MAX;
                            err  = 1'b1;
                        end else begin
                            ic_n = nb;
                        end
                        if (nb > rsv) begin
                            if (sum_st > BYTE_MAX) begin
                                st_n = BYTE_MAX;
                                err  = 1'b1;
                            end else begin
                                st_n = sum_st;
                            end
                        end
                    end else begin
                        if (sum_hc > BYTE_MAX) begin
                            hc_n = BYTE_MAX;
                            err  = 1'b1;
                        end else begin
                            hc_n = sum_hc;
                        end
                    end
                    if (&cur.ingress_packets) begin
                        err = 1'b1;
                    end else begin
                        ip_n = cur.ingress_packets + 1'b1;
                    end
                end
            end
            CMD_ING_REL: begin
                hc_n = hc - fh;
                if (rest > ic) begin
                    ic_n = '0;
                    err  = 1'b1;
                end else begin
                    ic_n = ic - rest;
                end
                if (fs > st) begin
                    st_n = '0;
                    err  = 1'b1;
                end else begin
                    st_n = st - fs;
                end
                if (cur.ingress_packets == '0) begin
                    err = 1'b1;
                end else begin
                    ip_n = cur.ingress_packets - 1'b1;
                end
            end
            CMD_EGR_ENQ: begin
                if (sum_ec > BYTE_MAX) begin
                    ec_n = BYTE_MAX;
                    err  = 1'b1;
                end else begin
                    ec_n = sum_ec;
                end
                if (&cur.egress_packets) begin
                    err = 1'b1;
                end else begin
                    ep_n = cur.egress_packets + 1'b1;
                end
            end
            CMD_EGR_REL: begin
                if (sz > ec) begin
                    ec_n = '0;
                    err  = 1'b1;
                end else begin
                    ec_n = ec - sz;
                end
                if (cur.egress_packets == '0) begin
                    err = 1'b1;
                end else begin
                    ep_n = cur.egress_packets - 1'b1;
                end
            end
            CMD_SET_PAUSE: p_n = 1'b1;
            CMD_CLR_PAUSE: p_n = 1'b0;
            default: begin
                p_n = cur.paused_flag;
            end
        endcase

        nsu = (ic_n > rsv) ? ic_n - rsv : '0;

        in_range = (32'(item.port) < 32'(NUM_PORTS)) && (32'(item.queue) < 32'(NUM_QUEUES));

        nxt.ingress_count   = BYTE_WIDTH'(ic_n);
        nxt.headroom_count  = BYTE_WIDTH'(hc_n);
        nxt.egress_count    = BYTE_WIDTH'(ec_n);
        nxt.paused_flag     = p_n;
        nxt.ingress_packets = ip_n;
        nxt.egress_packets  = ep_n;
        shared_nxt          = BYTE_WIDTH'(st_n);

        mid = '0;
        if (in_range) begin
            mid.res.admitted      = admit;
            mid.res.pause_needed  = !p_n && (hc_n != '0 || nsu >= thr);
            mid.res.resume_needed = p_n && hc_n == '0 &&
                                    (nsu == '0 || nsu + CALC_W'(cfg.resume_margin) <= thr);
            mid.res.ecn_mark      = 1'b0;
            mid.res.ingress_level = LEVEL_W'(ic_n);
            mid.res.egress_level  = LEVEL_W'(ec_n);
            mid.res.shared_level  = LEVEL_W'(st_n);
            mid.res.count_error   = err;
            mid.ecn_en            = item.queue != '0;
            mid.above_kmax        = ec_n > kmax;
            mid.above_kmin        = ec_n > kmin;
            mid.lvl_diff          = BYTE_WIDTH'(ec_n - kmin);
            mid.ecn_span          = cfg.ecn_kmax - cfg.ecn_kmin;
            mid.rnd               = item.random_value;
        end
    end

endmodule

FILE: sv/pfcba_ecn.sv
// ECN decision by cross-multiplication and the result register toward the output channel.
// Depends on pfcba_pkg for the intermediate and result types.
module pfcba_ecn (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                mid_valid,
    input  pfcba_pkg::pfcba_mid_t               mid,
    input  logic [pfcba_pkg::PROB_W-1:0]        ecn_pmax,
    output logic                                mid_take,
    output logic                                m_valid,
    input  logic                                m_ready,
    output pfcba_pkg::pfcba_out_t               m_data
);
    import pfcba_pkg::*;

    logic [ECN_PROD_W-1:0] lhs;
    logic [ECN_PROD_W-1:0] rhs;
    logic                  mark;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    pfcba_out_t            out_data_reg;
    pfcba_out_t            out_data_next;

    always_comb begin
        lhs  = ECN_PROD_W'(mid.rnd) * ECN_PROD_W'(mid.ecn_span);
        rhs  = ECN_PROD_W'(ecn_pmax) * ECN_PROD_W'(mid.lvl_diff);
        mark = mid.ecn_en && (mid.above_kmax || (mid.above_kmin && lhs < rhs));
        out_data_next          = mid.res;
        out_data_next.ecn_mark = mark;
    end

    assign mid_take = mid_valid && (!out_valid_reg || m_ready);
    assign m_valid  = out_valid_reg;
    assign m_data   = out_data_reg;

    always_comb begin
        out_valid_next = out_valid_reg;
        if (mid_take) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (mid_take) begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

FILE: sv/pfc_buffer_admission_ecn.sv
// Top level of the switch buffer manager: PFC headroom admission and RED-style ECN marking.
// Depends on pfcba_pkg, pfcba_regs, pfcba_qstore, pfcba_update, pfcba_ecn and the defines header.
//
//   Channel   Ports                                 Transaction
//   input     s_valid, s_ready, s_data              one packet event
//   output    m_valid, m_ready, m_data              one result per event
//   config    psel, penable, pwrite, paddr,         one register write or read
//             pwdata, prdata, pready
//
// An event takes two steps: on accept the queue entry is read from the counter memory,
// and in the update state it is updated and written back, which waits while the ECN
// stage still holds a result; a new event is accepted only after the last one is written back.
// The ECN compare works on a registered copy of the update result and overlaps with the next event.
// After reset the counter memory is cleared one entry at a time, all 512 entries, during which s_ready is low.
// A stalled output holds the update stage, which then holds s_ready low.
`include "pfc_buffer_admission_ecn_defines.svh"

module pfc_buffer_admission_ecn (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  pfcba_pkg::pfcba_in_t                s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output pfcba_pkg::pfcba_out_t               m_data,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [pfcba_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [pfcba_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [pfcba_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                pready
);
    import pfcba_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic                  state_reg;
    logic                  state_next;
    pfcba_in_t             item_reg;
    pfcba_mid_t            mid_reg;
    logic                  mid_valid_reg;
    logic                  mid_valid_next;
    logic [BYTE_WIDTH-1:0] shared_reg;

    pfcba_cfg_t            cfg;
    pfcba_qentry_t         cur_entry;
    pfcba_qentry_t         nxt_entry;
    logic [BYTE_WIDTH-1:0] shared_nxt;
    pfcba_mid_t            mid_nxt;
    logic                  in_range;
    logic                  clr_busy;
    logic                  mid_take;
    logic                  accept;
    logic                  exec_done;

    assign s_ready   = (state_reg == ST_IDLE) && !clr_busy;
    assign accept    = s_valid && s_ready;
    assign exec_done = (state_reg == ST_EXEC) && (!mid_valid_reg || mid_take);

    pfcba_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pfcba_qstore u_qstore (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_en    (accept),
        .rd_addr  (qidx(s_data.port, s_data.queue)),
        .rd_data  (cur_entry),
        .wr_en    (exec_done && in_range),
        .wr_addr  (qidx(item_reg.port, item_reg.queue)),
        .wr_data  (nxt_entry),
        .clr_busy (clr_busy)
    );

    pfcba_update u_update (
        .item       (item_reg),
        .cur        (cur_entry),
        .shared_cur (shared_reg),
        .cfg        (cfg),
        .in_range   (in_range),
        .nxt        (nxt_entry),
        .shared_nxt (shared_nxt),
        .mid        (mid_nxt)
    );

    pfcba_ecn u_ecn (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .mid_valid (mid_valid_reg),
        .mid       (mid_reg),
        .ecn_pmax  (cfg.ecn_pmax),
        .mid_take  (mid_take),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (exec_done) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        mid_valid_next = mid_valid_reg;
        if (exec_done) begin
            mid_valid_next = 1'b1;
        end else if (mid_take) begin
            mid_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            mid_valid_reg <= 1'b0;
            shared_reg    <= '0;
        end else begin
            state_reg     <= state_next;
            mid_valid_reg <= mid_valid_next;
            if (exec_done && in_range) begin
                shared_reg <= shared_nxt;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= s_data;
        end
        if (exec_done) begin
            mid_reg <= mid_nxt;
        end
    end

    `PFCBA_ASSERT_RST(a_accept_starts_exec, aclk, aresetn, accept |=> state_reg == ST_EXEC, "accepted transaction did not start the update cycle")
    `PFCBA_ASSERT_ALWAYS(a_no_accept_in_clear, aclk, clr_busy |-> !s_ready, "input ready while the counter memory is being cleared")
    `PFCBA_ASSERT_RST(a_exec_fills_mid, aclk, aresetn, (state_reg == ST_EXEC) && !mid_valid_reg |=> mid_valid_reg && (state_reg == ST_IDLE), "update cycle did not hand its result to the ECN stage")

endmodule
